FILE: hw/rtl/bcgp_pkg.sv
// ----------------------------------------------------------------------------
// bcgp_pkg: shared constants and types for the box corner ground projection
// Fixed-point widths of every pipeline section, register codes and the
// configuration and tag structures that travel between the modules.
// ----------------------------------------------------------------------------
package bcgp_pkg;

	localparam int PIXEL_BITS    = 12;
	localparam int OUT_FRAC_BITS = 8;
	localparam int NORM_FRAC     = 20;
	localparam int PIX_FRAC      = 4;
	localparam int TRIG_FRAC     = 14;

	// Magnitude width of a pixel offset from the principal point.
	localparam int MW   = (PIXEL_BITS + PIX_FRAC > 16) ? PIXEL_BITS + PIX_FRAC : 16;
	// Normalised coordinate: quotient bits and signed width.
	localparam int QN   = MW + NORM_FRAC;
	localparam int NV   = QN + 1;
	// Product of a Q1.14 trig value and a normalised coordinate.
	localparam int PW   = NV + 16;
	// Signed width of the rotated ray components.
	localparam int RW   = ((PW - TRIG_FRAC > 22) ? PW - TRIG_FRAC : 22) + 1;
	// Projection numerator and scaled dividend.
	localparam int NUMW = 16 + RW;
	localparam int NW   = NUMW + OUT_FRAC_BITS;
	localparam int QB   = 32;
	localparam int HW   = NW - QB;
	localparam int TW   = ((HW > RW) ? HW : RW) + 1;

	localparam int CFG_W = 20;
	localparam int IDX_W = 3;

	localparam logic [IDX_W-1:0] REG_CENTER_X  = 3'd0;
	localparam logic [IDX_W-1:0] REG_CENTER_Y  = 3'd1;
	localparam logic [IDX_W-1:0] REG_FOCAL_X   = 3'd2;
	localparam logic [IDX_W-1:0] REG_FOCAL_Y   = 3'd3;
	localparam logic [IDX_W-1:0] REG_COS_PITCH = 3'd4;
	localparam logic [IDX_W-1:0] REG_SIN_PITCH = 3'd5;
	localparam logic [IDX_W-1:0] REG_HEIGHT    = 3'd6;
	localparam logic [IDX_W-1:0] REG_MIN_DEN   = 3'd7;

	localparam logic [1:0] CORNER_LT = 2'd0;
	localparam logic [1:0] CORNER_RT = 2'd1;
	localparam logic [1:0] CORNER_RB = 2'd2;
	localparam logic [1:0] CORNER_LB = 2'd3;

	typedef struct packed {
		logic        [15:0] center_x;
		logic        [15:0] center_y;
		logic        [15:0] focal_x;
		logic        [15:0] focal_y;
		logic signed [15:0] cos_pitch;
		logic signed [15:0] sin_pitch;
		logic        [15:0] camera_height;
		logic        [19:0] min_denominator;
	} cfg_t;

	typedef struct packed {
		logic [1:0] idx;
		logic       ok;
	} tag_t;

endpackage

FILE: hw/rtl/bcgp_norm.sv
// ----------------------------------------------------------------------------
// bcgp_norm: normalisation divider pipeline
// Divides both pixel offsets, scaled to Q.20, by their focal lengths with a
// restoring divider that resolves one quotient bit per stage.
// ----------------------------------------------------------------------------
module bcgp_norm (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             adv,
	input  logic                             in_v,
	input  bcgp_pkg::tag_t                   in_tag,
	input  logic [bcgp_pkg::MW-1:0]          mag_x,
	input  logic                             neg_x,
	input  logic [bcgp_pkg::MW-1:0]          mag_y,
	input  logic                             neg_y,
	input  logic [15:0]                      focal_x,
	input  logic [15:0]                      focal_y,
	output logic                             out_v,
	output bcgp_pkg::tag_t                   out_tag,
	output logic signed [bcgp_pkg::NV-1:0]   xn,
	output logic signed [bcgp_pkg::NV-1:0]   yn
);

	localparam int N = bcgp_pkg::QN;
	localparam int M = bcgp_pkg::MW;

	// One restoring division step: returns the new remainder and shifted word.
	function automatic logic [M+N-1:0] div_step(logic [M-1:0] rem, logic [N-1:0] a,
			logic [M-1:0] f);
		logic [M:0] t;
		logic [M:0] d;
		logic       ge;
		t  = {rem, a[N-1]};
		d  = t - {1'b0, f};
		ge = (t >= {1'b0, f});
		return {(ge ? d[M-1:0] : t[M-1:0]), a[N-2:0], ge};
	endfunction

	logic           v_s    [N];
	bcgp_pkg::tag_t tag_s  [N];
	logic [M-1:0]   rx_s   [N];
	logic [N-1:0]   ax_s   [N];
	logic           nx_s   [N];
	logic [M-1:0]   ry_s   [N];
	logic [N-1:0]   ay_s   [N];
	logic           ny_s   [N];

	logic           v_i    [N];
	bcgp_pkg::tag_t tag_i  [N];
	logic [M-1:0]   rx_i   [N];
	logic [N-1:0]   ax_i   [N];
	logic           nx_i   [N];
	logic [M-1:0]   ry_i   [N];
	logic [N-1:0]   ay_i   [N];
	logic           ny_i   [N];

	logic [M-1:0]   fx;
	logic [M-1:0]   fy;

	assign fx = M'(focal_x);
	assign fy = M'(focal_y);

	// Each stage takes its operands from the one before; the first from the ports.
	genvar g;
	for (g = 0; g < N; g++) begin : g_in
		if (g == 0) begin : g_first
			assign v_i[g]   = in_v;
			assign tag_i[g] = in_tag;
			assign rx_i[g]  = '0;
			assign ax_i[g]  = N'({mag_x, {bcgp_pkg::NORM_FRAC{1'b0}}});
			assign nx_i[g]  = neg_x;
			assign ry_i[g]  = '0;
			assign ay_i[g]  = N'({mag_y, {bcgp_pkg::NORM_FRAC{1'b0}}});
			assign ny_i[g]  = neg_y;
		end else begin : g_next
			assign v_i[g]   = v_s[g-1];
			assign tag_i[g] = tag_s[g-1];
			assign rx_i[g]  = rx_s[g-1];
			assign ax_i[g]  = ax_s[g-1];
			assign nx_i[g]  = nx_s[g-1];
			assign ry_i[g]  = ry_s[g-1];
			assign ay_i[g]  = ay_s[g-1];
			assign ny_i[g]  = ny_s[g-1];
		end
	end

	// Valid bits of the divider stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) v_s[i] <= 1'b0;
		end else if (adv) begin
			for (int i = 0; i < N; i++) v_s[i] <= v_i[i];
		end
	end

	// Divider data, one quotient bit per stage for each lane.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < N; i++) begin
				tag_s[i]              <= tag_i[i];
				{rx_s[i], ax_s[i]}    <= div_step(rx_i[i], ax_i[i], fx);
				nx_s[i]               <= nx_i[i];
				{ry_s[i], ay_s[i]}    <= div_step(ry_i[i], ay_i[i], fy);
				ny_s[i]               <= ny_i[i];
			end
		end
	end

	assign out_v   = v_s[N-1];
	assign out_tag = tag_s[N-1];
	assign xn      = nx_s[N-1] ? -$signed({1'b0, ax_s[N-1]}) : $signed({1'b0, ax_s[N-1]});
	assign yn      = ny_s[N-1] ? -$signed({1'b0, ay_s[N-1]}) : $signed({1'b0, ay_s[N-1]});

endmodule

FILE: hw/rtl/bcgp_rot.sv
// ----------------------------------------------------------------------------
// bcgp_rot: pitch rotation and ray check
// Rotates the normalised ray by the camera pitch over two stages and decides
// whether the ray is steep enough to meet the ground.
// ----------------------------------------------------------------------------
module bcgp_rot (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             adv,
	input  logic                             in_v,
	input  bcgp_pkg::tag_t                   in_tag,
	input  logic signed [bcgp_pkg::NV-1:0]   xn,
	input  logic signed [bcgp_pkg::NV-1:0]   yn,
	input  logic signed [15:0]               cos_pitch,
	input  logic signed [15:0]               sin_pitch,
	input  logic [19:0]                      min_denominator,
	output logic                             out_v,
	output bcgp_pkg::tag_t                   out_tag,
	output logic [bcgp_pkg::RW-1:0]          mag_x,
	output logic [bcgp_pkg::RW-1:0]          mag_z,
	output logic [bcgp_pkg::RW-1:0]          den,
	output logic                             neg_x,
	output logic                             neg_z
);

	localparam int R = bcgp_pkg::RW;
	localparam int P = bcgp_pkg::PW;

	logic                  v_s1;
	bcgp_pkg::tag_t        tag_s1;
	logic signed [P-1:0]   pc_s1;
	logic signed [P-1:0]   ps_s1;
	logic signed [bcgp_pkg::NV-1:0] xn_s1;

	logic                  v_s2;
	bcgp_pkg::tag_t        tag_s2;
	logic [R-1:0]          mx_s2;
	logic [R-1:0]          mz_s2;
	logic [R-1:0]          md_s2;
	logic                  nx_s2;
	logic                  nz_s2;

	logic signed [R-1:0]   yd;
	logic signed [R-1:0]   zd;
	logic signed [R-1:0]   xw;
	logic [R-1:0]          ym;
	logic                  steep;

	// Second stage: floor shift back to Q.20 and add the trig offsets.
	always_comb begin
		yd    = R'(pc_s1 >>> bcgp_pkg::TRIG_FRAC) - (R'(sin_pitch) <<< 6);
		zd    = R'(ps_s1 >>> bcgp_pkg::TRIG_FRAC) + (R'(cos_pitch) <<< 6);
		xw    = R'(xn_s1);
		ym    = yd[R-1] ? R'(-yd) : R'(yd);
		steep = (ym != '0) && (ym >= R'(min_denominator));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
		end
	end

	// First stage multiplies, second stage forms magnitudes and signs.
	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s1     <= in_tag;
			pc_s1      <= P'(cos_pitch) * P'(yn);
			ps_s1      <= P'(sin_pitch) * P'(yn);
			xn_s1      <= xn;
			tag_s2.idx <= tag_s1.idx;
			tag_s2.ok  <= tag_s1.ok && steep;
			mx_s2      <= xw[R-1] ? R'(-xw) : R'(xw);
			mz_s2      <= zd[R-1] ? R'(-zd) : R'(zd);
			md_s2      <= ym;
			nx_s2      <= xw[R-1] ^ yd[R-1];
			nz_s2      <= zd[R-1] ^ yd[R-1];
		end
	end

	assign out_v   = v_s2;
	assign out_tag = tag_s2;
	assign mag_x   = mx_s2;
	assign mag_z   = mz_s2;
	assign den     = md_s2;
	assign neg_x   = nx_s2;
	assign neg_z   = nz_s2;

endmodule

FILE: hw/rtl/bcgp_proj.sv
// ----------------------------------------------------------------------------
// bcgp_proj: ground plane intersection
// Scales both ray components by the camera height, divides them by the ray
// height one bit per stage and saturates into the output register.
// ----------------------------------------------------------------------------
module bcgp_proj (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  logic                       in_v,
	input  bcgp_pkg::tag_t             in_tag,
	input  logic [bcgp_pkg::RW-1:0]    mag_x,
	input  logic [bcgp_pkg::RW-1:0]    mag_z,
	input  logic [bcgp_pkg::RW-1:0]    den,
	input  logic                       neg_x,
	input  logic                       neg_z,
	input  logic [15:0]                camera_height,
	output logic                       out_v,
	output logic [1:0]                 corner_index,
	output logic                       corner_valid,
	output logic signed [31:0]         ground_x,
	output logic [15:0]                ground_y,
	output logic signed [31:0]         ground_z,
	output logic                       last_corner
);

	localparam int R = bcgp_pkg::RW;
	localparam int Q = bcgp_pkg::QB;
	localparam int U = bcgp_pkg::NUMW;
	localparam int W = bcgp_pkg::NW;
	localparam int T = bcgp_pkg::TW;

	// One restoring division step on a remainder below the divisor.
	function automatic logic [R+Q-1:0] div_step(logic [R-1:0] rem, logic [Q-1:0] a,
			logic [R-1:0] f);
		logic [R:0] t;
		logic [R:0] d;
		logic       ge;
		t  = {rem, a[Q-1]};
		d  = t - {1'b0, f};
		ge = (t >= {1'b0, f});
		return {(ge ? d[R-1:0] : t[R-1:0]), a[Q-2:0], ge};
	endfunction

	// Rounding toward zero is already done by the divider: apply the sign and clamp to the 32-bit range.
	function automatic logic [31:0] saturate(logic ok, logic ovf, logic neg, logic [31:0] q);
		logic [31:0] r;
		if (!ok) begin
			r = '0;
		end else if (neg) begin
			r = (ovf || (q > 32'h8000_0000)) ? 32'h8000_0000 : (32'd0 - q);
		end else begin
			r = (ovf || q[31]) ? 32'h7FFF_FFFF : q;
		end
		return r;
	endfunction

	// Multiply stage.
	logic            v_s1;
	bcgp_pkg::tag_t  tag_s1;
	logic [U-1:0]    numx_s1;
	logic [U-1:0]    numz_s1;
	logic [R-1:0]    den_s1;
	logic            nx_s1;
	logic            nz_s1;

	// Overflow check and divider set-up stage.
	logic            v_s2;
	bcgp_pkg::tag_t  tag_s2;
	logic [R-1:0]    rx_s2;
	logic [Q-1:0]    ax_s2;
	logic            ox_s2;
	logic [R-1:0]    rz_s2;
	logic [Q-1:0]    az_s2;
	logic            oz_s2;
	logic [R-1:0]    den_s2;
	logic            nx_s2;
	logic            nz_s2;

	// Divider stages.
	logic            v_s    [Q];
	bcgp_pkg::tag_t  tag_s  [Q];
	logic [R-1:0]    rx_s   [Q];
	logic [Q-1:0]    ax_s   [Q];
	logic            ox_s   [Q];
	logic [R-1:0]    rz_s   [Q];
	logic [Q-1:0]    az_s   [Q];
	logic            oz_s   [Q];
	logic [R-1:0]    den_s  [Q];
	logic            nx_s   [Q];
	logic            nz_s   [Q];

	logic            v_i    [Q];
	bcgp_pkg::tag_t  tag_i  [Q];
	logic [R-1:0]    rx_i   [Q];
	logic [Q-1:0]    ax_i   [Q];
	logic            ox_i   [Q];
	logic [R-1:0]    rz_i   [Q];
	logic [Q-1:0]    az_i   [Q];
	logic            oz_i   [Q];
	logic [R-1:0]    den_i  [Q];
	logic            nx_i   [Q];
	logic            nz_i   [Q];

	// Output register.
	logic            v_q;
	logic [1:0]      idx_q;
	logic            ok_q;
	logic [31:0]     gx_q;
	logic [15:0]     gy_q;
	logic [31:0]     gz_q;

	logic [W-1:0]    dvx;
	logic [W-1:0]    dvz;

	assign dvx = W'(numx_s1) << bcgp_pkg::OUT_FRAC_BITS;
	assign dvz = W'(numz_s1) << bcgp_pkg::OUT_FRAC_BITS;

	genvar g;
	for (g = 0; g < Q; g++) begin : g_in
		if (g == 0) begin : g_first
			assign v_i[g]   = v_s2;
			assign tag_i[g] = tag_s2;
			assign rx_i[g]  = rx_s2;
			assign ax_i[g]  = ax_s2;
			assign ox_i[g]  = ox_s2;
			assign rz_i[g]  = rz_s2;
			assign az_i[g]  = az_s2;
			assign oz_i[g]  = oz_s2;
			assign den_i[g] = den_s2;
			assign nx_i[g]  = nx_s2;
			assign nz_i[g]  = nz_s2;
		end else begin : g_next
			assign v_i[g]   = v_s[g-1];
			assign tag_i[g] = tag_s[g-1];
			assign rx_i[g]  = rx_s[g-1];
			assign ax_i[g]  = ax_s[g-1];
			assign ox_i[g]  = ox_s[g-1];
			assign rz_i[g]  = rz_s[g-1];
			assign az_i[g]  = az_s[g-1];
			assign oz_i[g]  = oz_s[g-1];
			assign den_i[g] = den_s[g-1];
			assign nx_i[g]  = nx_s[g-1];
			assign nz_i[g]  = nz_s[g-1];
		end
	end

	// Valid bits of every stage of this section.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			for (int i = 0; i < Q; i++) v_s[i] <= 1'b0;
			v_q  <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			for (int i = 0; i < Q; i++) v_s[i] <= v_i[i];
			v_q  <= v_s[Q-1];
		end
	end

	// Data path: multiply, overflow check, divide and saturate.
	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s1  <= in_tag;
			numx_s1 <= U'(camera_height) * U'(mag_x);
			numz_s1 <= U'(camera_height) * U'(mag_z);
			den_s1  <= den;
			nx_s1   <= neg_x;
			nz_s1   <= neg_z;

			// A high part at or above the divisor means the quotient needs more than 32 bits.
			tag_s2  <= tag_s1;
			rx_s2   <= R'(dvx[W-1:Q]);
			ax_s2   <= dvx[Q-1:0];
			ox_s2   <= (T'(dvx[W-1:Q]) >= T'(den_s1));
			rz_s2   <= R'(dvz[W-1:Q]);
			az_s2   <= dvz[Q-1:0];
			oz_s2   <= (T'(dvz[W-1:Q]) >= T'(den_s1));
			den_s2  <= den_s1;
			nx_s2   <= nx_s1;
			nz_s2   <= nz_s1;

			for (int i = 0; i < Q; i++) begin
				tag_s[i]           <= tag_i[i];
				{rx_s[i], ax_s[i]} <= div_step(rx_i[i], ax_i[i], den_i[i]);
				ox_s[i]            <= ox_i[i];
				{rz_s[i], az_s[i]} <= div_step(rz_i[i], az_i[i], den_i[i]);
				oz_s[i]            <= oz_i[i];
				den_s[i]           <= den_i[i];
				nx_s[i]            <= nx_i[i];
				nz_s[i]            <= nz_i[i];
			end

			idx_q <= tag_s[Q-1].idx;
			ok_q  <= tag_s[Q-1].ok;
			gx_q  <= saturate(tag_s[Q-1].ok, ox_s[Q-1], nx_s[Q-1], ax_s[Q-1]);
			gz_q  <= saturate(tag_s[Q-1].ok, oz_s[Q-1], nz_s[Q-1], az_s[Q-1]);
			gy_q  <= tag_s[Q-1].ok ? camera_height : 16'd0;
		end
	end

	assign out_v        = v_q;
	assign corner_index = idx_q;
	assign corner_valid = ok_q;
	assign ground_x     = $signed(gx_q);
	assign ground_y     = gy_q;
	assign ground_z     = $signed(gz_q);
	assign last_corner  = (idx_q == bcgp_pkg::CORNER_LB);

endmodule

FILE: hw/rtl/box_corner_ground_projection.sv
// ----------------------------------------------------------------------------
// box_corner_ground_projection: detection box corners onto the ground plane
// Throughput: one corner result per cycle while the output is not stalled;
// a new box is taken as the last corner of the one before issues. The corner
// sequencer issuing four corners into a single pipeline sets this rate.
// Reset clears all valid bits and loads the register reset values; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module box_corner_ground_projection (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [bcgp_pkg::IDX_W-1:0]  cfg_index,
	input  logic [bcgp_pkg::CFG_W-1:0]  cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [11:0]                 box_left,
	input  logic [11:0]                 box_top,
	input  logic [11:0]                 box_right,
	input  logic [11:0]                 box_bottom,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  corner_index,
	output logic                        corner_valid,
	output logic signed [31:0]          ground_x,
	output logic [15:0]                 ground_y,
	output logic signed [31:0]          ground_z,
	output logic                        last_corner
);

	localparam int PB = bcgp_pkg::PIXEL_BITS;
	localparam int M  = bcgp_pkg::MW;

	bcgp_pkg::cfg_t  cfg_q;

	logic [PB-1:0]   left_q;
	logic [PB-1:0]   top_q;
	logic [PB-1:0]   right_q;
	logic [PB-1:0]   bottom_q;
	logic            held_q;
	logic [1:0]      k_q;

	logic            adv;
	logic            issue;
	logic            accept;
	logic [PB-1:0]   u;
	logic [PB-1:0]   v;
	logic [M:0]      dx;
	logic [M:0]      dy;

	logic            v_s1;
	bcgp_pkg::tag_t  tag_s1;
	logic [M-1:0]    mx_s1;
	logic            nx_s1;
	logic [M-1:0]    my_s1;
	logic            ny_s1;

	logic            n_v;
	bcgp_pkg::tag_t  n_tag;
	logic signed [bcgp_pkg::NV-1:0] n_xn;
	logic signed [bcgp_pkg::NV-1:0] n_yn;

	logic            r_v;
	bcgp_pkg::tag_t  r_tag;
	logic [bcgp_pkg::RW-1:0] r_mx;
	logic [bcgp_pkg::RW-1:0] r_mz;
	logic [bcgp_pkg::RW-1:0] r_den;
	logic            r_nx;
	logic            r_nz;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_x        <= 16'd0;
			cfg_q.center_y        <= 16'd0;
			cfg_q.focal_x         <= 16'd16;
			cfg_q.focal_y         <= 16'd16;
			cfg_q.cos_pitch       <= 16'sd16384;
			cfg_q.sin_pitch       <= 16'sd0;
			cfg_q.camera_height   <= 16'd0;
			cfg_q.min_denominator <= 20'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				bcgp_pkg::REG_CENTER_X:  cfg_q.center_x        <= cfg_data[15:0];
				bcgp_pkg::REG_CENTER_Y:  cfg_q.center_y        <= cfg_data[15:0];
				bcgp_pkg::REG_FOCAL_X:   cfg_q.focal_x         <= cfg_data[15:0];
				bcgp_pkg::REG_FOCAL_Y:   cfg_q.focal_y         <= cfg_data[15:0];
				bcgp_pkg::REG_COS_PITCH: cfg_q.cos_pitch       <= $signed(cfg_data[15:0]);
				bcgp_pkg::REG_SIN_PITCH: cfg_q.sin_pitch       <= $signed(cfg_data[15:0]);
				bcgp_pkg::REG_HEIGHT:    cfg_q.camera_height   <= cfg_data[15:0];
				bcgp_pkg::REG_MIN_DEN:   cfg_q.min_denominator <= cfg_data[19:0];
				default: ;
			endcase
		end
	end

	// The whole pipeline moves unless a finished result waits at the output.
	assign adv      = !(out_valid && out_stall);
	assign issue    = held_q && adv;
	assign in_stall = held_q && !((k_q == bcgp_pkg::CORNER_LB) && adv);
	assign accept   = in_valid && !in_stall;

	// Corner sequencer: holds one box and issues its four corners in order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 1'b0;
			k_q    <= bcgp_pkg::CORNER_LT;
		end else begin
			if (issue) begin
				k_q <= k_q + 2'd1;
				if (k_q == bcgp_pkg::CORNER_LB) held_q <= 1'b0;
			end
			if (accept) begin
				held_q <= 1'b1;
				k_q    <= bcgp_pkg::CORNER_LT;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			left_q   <= PB'(box_left);
			top_q    <= PB'(box_top);
			right_q  <= PB'(box_right);
			bottom_q <= PB'(box_bottom);
		end
	end

	// Corner pixel and its offset from the principal point.
	always_comb begin
		u  = ((k_q == bcgp_pkg::CORNER_LT) || (k_q == bcgp_pkg::CORNER_LB)) ? left_q : right_q;
		v  = ((k_q == bcgp_pkg::CORNER_LT) || (k_q == bcgp_pkg::CORNER_RT)) ? top_q : bottom_q;
		dx = {1'b0, M'({u, {bcgp_pkg::PIX_FRAC{1'b0}}})} - {1'b0, M'(cfg_q.center_x)};
		dy = {1'b0, M'({v, {bcgp_pkg::PIX_FRAC{1'b0}}})} - {1'b0, M'(cfg_q.center_y)};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s1.idx <= k_q;
			tag_s1.ok  <= (cfg_q.focal_x != 16'd0) && (cfg_q.focal_y != 16'd0);
			nx_s1      <= dx[M];
			mx_s1      <= dx[M] ? M'(-dx) : dx[M-1:0];
			ny_s1      <= dy[M];
			my_s1      <= dy[M] ? M'(-dy) : dy[M-1:0];
		end
	end

	bcgp_norm u_norm (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_v    (v_s1),
		.in_tag  (tag_s1),
		.mag_x   (mx_s1),
		.neg_x   (nx_s1),
		.mag_y   (my_s1),
		.neg_y   (ny_s1),
		.focal_x (cfg_q.focal_x),
		.focal_y (cfg_q.focal_y),
		.out_v   (n_v),
		.out_tag (n_tag),
		.xn      (n_xn),
		.yn      (n_yn)
	);

	bcgp_rot u_rot (
		.clk             (clk),
		.arst_n          (arst_n),
		.adv             (adv),
		.in_v            (n_v),
		.in_tag          (n_tag),
		.xn              (n_xn),
		.yn              (n_yn),
		.cos_pitch       (cfg_q.cos_pitch),
		.sin_pitch       (cfg_q.sin_pitch),
		.min_denominator (cfg_q.min_denominator),
		.out_v           (r_v),
		.out_tag         (r_tag),
		.mag_x           (r_mx),
		.mag_z           (r_mz),
		.den             (r_den),
		.neg_x           (r_nx),
		.neg_z           (r_nz)
	);

	bcgp_proj u_proj (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.in_v          (r_v),
		.in_tag        (r_tag),
		.mag_x         (r_mx),
		.mag_z         (r_mz),
		.den           (r_den),
		.neg_x         (r_nx),
		.neg_z         (r_nz),
		.camera_height (cfg_q.camera_height),
		.out_v         (out_valid),
		.corner_index  (corner_index),
		.corner_valid  (corner_valid),
		.ground_x      (ground_x),
		.ground_y      (ground_y),
		.ground_z      (ground_z),
		.last_corner   (last_corner)
	);

endmodule
